// ===== design/fpwe_pkg.sv =====
// Shared types, codes and constants of the frame pool window evictor.
`default_nettype none
package fpwe_pkg;

	localparam int SLOTS_DEF    = 32;
	localparam int BUF_BITS_DEF = 8;

	// Byte budget of the pool; pixels cost four bytes each
	localparam logic [29:0] BYTE_LIMIT = 30'd1000000000;
	localparam int          PIX_SHIFT  = 2;

	localparam logic signed [31:0] FRAME_MIN = 32'sh8000_0000;

	localparam logic [1:0] CFG_POOL_SIZE    = 2'd0;
	localparam logic [1:0] CFG_READ_AHEAD   = 2'd1;
	localparam logic [1:0] CFG_FRAME_LENGTH = 2'd2;

	typedef enum logic [1:0] {
		CMD_POSITION = 2'd0,
		CMD_INSERT   = 2'd1,
		CMD_LOOKUP   = 2'd2,
		CMD_CANCEL   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_RECYCLE = 2'd0,
		KIND_STATUS  = 2'd1,
		KIND_LOOKUP  = 2'd2,
		KIND_STOP    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] frame;
		logic               backward;
		logic [7:0]         buffer_id;
		logic [12:0]        pic_width;
		logic [12:0]        pic_height;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         out_buffer;
		logic signed [31:0] out_frame;
		logic               out_backward;
		logic               hit;
		logic               overflow;
		logic               last;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN_INIT,
		OP_AREA,
		OP_LIM_STEP,
		OP_WIN,
		OP_EVICT,
		OP_COMPACT,
		OP_COMPACT_END,
		OP_FIND,
		OP_PUSH_POS,
		OP_PUSH_LOOK,
		OP_REPLACE,
		OP_PUSH_OVF,
		OP_SHIFT_INIT,
		OP_SHIFT,
		OP_PLACE,
		OP_PUSH_STOP,
		OP_DRAIN,
		OP_CLEAR,
		OP_FLUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   desc;
	} ctl_t;

	typedef struct packed {
		logic n_zero;
		logic n_full;
		logic fl_zero;
		logic play_bw;
		logic lim_last;
		logic excess_zero;
		logic rem_zero;
		logic stop;
		logic found;
		logic any_kill;
		logic wr_eq_pos;
	} sts_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_EV_START,
		S_EV_RD,
		S_EV_AREA,
		S_EV_LIM,
		S_EV_WIN,
		S_EV_INIT,
		S_EV_READ,
		S_EV_EVAL,
		S_CP_INIT,
		S_CP_READ,
		S_CP_EVAL,
		S_FD_INIT,
		S_FD_READ,
		S_FD_EVAL,
		S_SH_READ,
		S_SH_EVAL,
		S_CN_STOP,
		S_CN_INIT,
		S_CN_READ,
		S_CN_EVAL,
		S_FLUSH
	} state_t;

endpackage
`default_nettype wire

// ===== design/fpwe_dp.sv =====
// Datapath: sorted entry memory, limit search, window test and result staging.
`default_nettype none
module fpwe_dp #(
	parameter int SLOTS    = fpwe_pkg::SLOTS_DEF,
	parameter int BUF_BITS = fpwe_pkg::BUF_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  fpwe_pkg::in_item_t   item,
	input  wire                  cfg_we,
	input  wire [1:0]            cfg_index,
	input  wire [30:0]           cfg_data,
	input  fpwe_pkg::ctl_t       ctl,
	output fpwe_pkg::sts_t       sts,
	output logic                 result_valid,
	output fpwe_pkg::out_item_t  result
);
	import fpwe_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	typedef struct packed {
		logic signed [31:0]  frame;
		logic [BUF_BITS-1:0] buffer;
		logic [12:0]         w;
		logic [12:0]         h;
	} ent_t;

	function automatic logic signed [31:0] clip(input logic signed [31:0] f,
		input logic [30:0] fl);
		logic signed [31:0] lim;
		lim = $signed({1'b0, fl});
		if (f < 0)
			clip = '0;
		else if (f >= lim)
			clip = lim;
		else
			clip = f;
	endfunction

	ent_t mem [SLOTS];
	ent_t rd_q, new_q;

	logic [4:0]          pool_q;
	logic [7:0]          ra_q;
	logic [30:0]         fl_q;
	logic signed [31:0]  play_pos_q;
	logic                play_bw_q;
	logic signed [31:0]  key_q;
	logic [CW-1:0]       n_q, idx_q, wr_q, pos_q, rem_q, excess_q;
	logic                dir_q;
	logic [4:0]          lim_q;
	logic [2:0]          bit_q;
	logic [25:0]         bytes_q;
	logic signed [33:0]  lo_q, hi_q;
	logic [SLOTS-1:0]    kill_q;
	logic                any_kill_q, found_q, stop_q;
	logic [BUF_BITS-1:0] fbuf_q;
	out_item_t           pend_q;
	logic                pend_v_q;

	logic signed [31:0]  p;
	logic [4:0]          cand;
	logic [32:0]         prod;
	logic                lim_ok;
	logic signed [33:0]  f34, p34, l34, r34;
	logic                out_win;
	logic                push;
	out_item_t           res_new;
	out_item_t           pend_out;
	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	ent_t                mem_wd;
	logic [6:0]          n7, l7;

	assign p    = clip(play_pos_q, fl_q);
	assign cand = lim_q | (5'd1 << bit_q);
	assign prod = 33'(cand) * (33'(bytes_q) << PIX_SHIFT);
	assign lim_ok = (cand <= pool_q) && (prod <= 33'(BYTE_LIMIT));
	assign f34 = 34'(rd_q.frame);
	assign p34 = 34'(p);
	assign l34 = $signed({29'd0, lim_q});
	assign r34 = $signed({26'd0, ra_q});
	assign out_win = (f34 < lo_q) || (f34 >= hi_q);
	assign n7 = 7'(n_q);
	assign l7 = 7'(lim_q);

	// Outgoing beat: flag last only on the flush that ends the command
	always_comb begin
		pend_out      = pend_q;
		pend_out.last = (ctl.op == OP_FLUSH);
	end

	always_comb begin
		push    = 1'b0;
		res_new = '0;
		mem_we  = 1'b0;
		mem_wa  = wr_q[AW-1:0];
		mem_wd  = rd_q;
		case (ctl.op)
			OP_EVICT: begin
				push = out_win;
				res_new.kind = KIND_RECYCLE;
				res_new.out_buffer = 8'(rd_q.buffer);
				res_new.out_frame = rd_q.frame;
			end
			OP_DRAIN: begin
				push = 1'b1;
				res_new.kind = KIND_RECYCLE;
				res_new.out_buffer = 8'(rd_q.buffer);
				res_new.out_frame = rd_q.frame;
			end
			OP_PUSH_POS: begin
				push = 1'b1;
				res_new.kind = KIND_STATUS;
				res_new.out_frame = key_q;
				res_new.out_backward = play_bw_q;
				res_new.hit = found_q;
			end
			OP_PUSH_LOOK: begin
				push = 1'b1;
				res_new.kind = KIND_LOOKUP;
				res_new.out_buffer = found_q ? 8'(fbuf_q) : 8'd0;
				res_new.out_frame = key_q;
				res_new.hit = found_q;
			end
			OP_REPLACE: begin
				push = 1'b1;
				res_new.kind = KIND_RECYCLE;
				res_new.out_buffer = 8'(fbuf_q);
				res_new.out_frame = key_q;
				mem_we = 1'b1;
				mem_wa = idx_q[AW-1:0];
				mem_wd = new_q;
			end
			OP_PUSH_OVF: begin
				push = 1'b1;
				res_new.kind = KIND_RECYCLE;
				res_new.out_buffer = 8'(new_q.buffer);
				res_new.out_frame = key_q;
				res_new.overflow = 1'b1;
			end
			OP_PUSH_STOP: begin
				push = 1'b1;
				res_new.kind = KIND_STOP;
			end
			OP_COMPACT: mem_we = !kill_q[idx_q[AW-1:0]];
			OP_SHIFT:   mem_we = 1'b1;
			OP_PLACE: begin
				mem_we = 1'b1;
				mem_wa = pos_q[AW-1:0];
				mem_wd = new_q;
			end
			default: ;
		endcase
	end

	// Entry memory: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q <= mem[idx_q[AW-1:0]];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD) begin
			key_q <= (item.cmd == CMD_LOOKUP) ? clip(item.frame, fl_q) : item.frame;
			new_q.frame  <= item.frame;
			new_q.buffer <= BUF_BITS'(item.buffer_id);
			new_q.w      <= item.pic_width;
			new_q.h      <= item.pic_height;
		end
		if (ctl.op == OP_AREA)
			bytes_q <= 26'(rd_q.w) * 26'(rd_q.h);
		if (ctl.op == OP_WIN) begin
			lo_q <= play_bw_q ? p34 - l34 : p34 - l34 - r34;
			hi_q <= play_bw_q ? p34 + l34 + r34 : p34 + l34;
		end
		if (ctl.op == OP_FIND && rd_q.frame == key_q)
			fbuf_q <= rd_q.buffer;
		if (push)
			pend_q <= res_new;
		if ((push || ctl.op == OP_FLUSH) && pend_v_q)
			result <= pend_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q       <= 5'd16;
			ra_q         <= 8'd8;
			fl_q         <= '0;
			play_pos_q   <= FRAME_MIN;
			play_bw_q    <= 1'b0;
			n_q          <= '0;
			idx_q        <= '0;
			wr_q         <= '0;
			pos_q        <= '0;
			rem_q        <= '0;
			excess_q     <= '0;
			dir_q        <= 1'b0;
			lim_q        <= '0;
			bit_q        <= '0;
			kill_q       <= '0;
			any_kill_q   <= 1'b0;
			found_q      <= 1'b0;
			stop_q       <= 1'b0;
			pend_v_q     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_POOL_SIZE:    pool_q <= cfg_data[4:0];
					CFG_READ_AHEAD:   ra_q   <= cfg_data[7:0];
					CFG_FRAME_LENGTH: fl_q   <= cfg_data;
					default: ;
				endcase
			end

			result_valid <= (push || ctl.op == OP_FLUSH) && pend_v_q;
			if (push)
				pend_v_q <= 1'b1;
			else if (ctl.op == OP_FLUSH)
				pend_v_q <= 1'b0;

			case (ctl.op)
				OP_LOAD: begin
					if (item.cmd == CMD_POSITION && fl_q != '0) begin
						play_pos_q <= item.frame;
						play_bw_q  <= item.backward;
					end
				end
				OP_SCAN_INIT: begin
					idx_q   <= ctl.desc ? n_q - CW'(1) : '0;
					dir_q   <= ctl.desc;
					rem_q   <= n_q;
					wr_q    <= '0;
					found_q <= 1'b0;
					stop_q  <= 1'b0;
				end
				OP_AREA: begin
					lim_q <= '0;
					bit_q <= 3'd4;
				end
				OP_LIM_STEP: begin
					if (lim_ok)
						lim_q <= cand;
					bit_q <= bit_q - 3'd1;
				end
				OP_WIN: excess_q <= (n7 > l7) ? CW'(n7 - l7) : '0;
				OP_EVICT: begin
					if (out_win) begin
						kill_q[idx_q[AW-1:0]] <= 1'b1;
						any_kill_q <= 1'b1;
						excess_q   <= excess_q - CW'(1);
					end
					idx_q <= dir_q ? idx_q - CW'(1) : idx_q + CW'(1);
					rem_q <= rem_q - CW'(1);
				end
				OP_COMPACT: begin
					if (!kill_q[idx_q[AW-1:0]])
						wr_q <= wr_q + CW'(1);
					idx_q <= idx_q + CW'(1);
					rem_q <= rem_q - CW'(1);
				end
				OP_COMPACT_END: begin
					n_q        <= wr_q;
					kill_q     <= '0;
					any_kill_q <= 1'b0;
				end
				OP_FIND: begin
					if (rd_q.frame == key_q) begin
						found_q <= 1'b1;
						stop_q  <= 1'b1;
					end else if (rd_q.frame > key_q) begin
						stop_q <= 1'b1;
					end else begin
						idx_q <= idx_q + CW'(1);
						rem_q <= rem_q - CW'(1);
					end
				end
				OP_SHIFT_INIT: begin
					pos_q <= idx_q;
					wr_q  <= n_q;
					idx_q <= n_q - CW'(1);
				end
				OP_SHIFT: begin
					wr_q  <= wr_q - CW'(1);
					idx_q <= idx_q - CW'(1);
				end
				OP_PLACE: n_q <= n_q + CW'(1);
				OP_DRAIN: begin
					idx_q <= idx_q + CW'(1);
					rem_q <= rem_q - CW'(1);
				end
				OP_CLEAR: begin
					n_q        <= '0;
					play_pos_q <= FRAME_MIN;
				end
				default: ;
			endcase
		end
	end

	assign sts.n_zero      = (n_q == '0);
	assign sts.n_full      = (n_q == CW'(SLOTS));
	assign sts.fl_zero     = (fl_q == '0);
	assign sts.play_bw     = play_bw_q;
	assign sts.lim_last    = (bit_q == '0);
	assign sts.excess_zero = (excess_q == '0);
	assign sts.rem_zero    = (rem_q == '0);
	assign sts.stop        = stop_q;
	assign sts.found       = found_q;
	assign sts.any_kill    = any_kill_q;
	assign sts.wr_eq_pos   = (wr_q == pos_q);

endmodule
`default_nettype wire

// ===== design/fpwe_ctrl.sv =====
// Controller: sequences eviction, compaction, search, insertion and cancel.
`default_nettype none
module fpwe_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire [1:0]          cmd,
	input  fpwe_pkg::sts_t     sts,
	output fpwe_pkg::ctl_t     ctl,
	output logic               busy
);
	import fpwe_pkg::*;

	state_t state_q, state_d;
	cmd_t   cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_POSITION;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start)
				cmd_q <= cmd_t'(cmd);
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl.op   = OP_NONE;
		ctl.desc = 1'b0;
		busy     = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.op = OP_LOAD;
					unique case (cmd_t'(cmd))
						CMD_POSITION: state_d = sts.fl_zero ? S_IDLE : S_EV_START;
						CMD_INSERT:   state_d = S_EV_START;
						CMD_LOOKUP:   state_d = S_FD_INIT;
						CMD_CANCEL:   state_d = S_CN_STOP;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_EV_START: begin
				if (sts.n_zero) begin
					state_d = S_FD_INIT;
				end else begin
					ctl.op  = OP_SCAN_INIT;
					state_d = S_EV_RD;
				end
			end
			S_EV_RD:   state_d = S_EV_AREA;
			S_EV_AREA: begin
				ctl.op  = OP_AREA;
				state_d = S_EV_LIM;
			end
			S_EV_LIM: begin
				ctl.op = OP_LIM_STEP;
				if (sts.lim_last)
					state_d = S_EV_WIN;
			end
			S_EV_WIN: begin
				ctl.op  = OP_WIN;
				state_d = S_EV_INIT;
			end
			S_EV_INIT: begin
				if (sts.excess_zero) begin
					state_d = S_FD_INIT;
				end else begin
					ctl.op   = OP_SCAN_INIT;
					ctl.desc = sts.play_bw;
					state_d  = S_EV_READ;
				end
			end
			S_EV_READ: begin
				if (sts.excess_zero || sts.rem_zero)
					state_d = sts.any_kill ? S_CP_INIT : S_FD_INIT;
				else
					state_d = S_EV_EVAL;
			end
			S_EV_EVAL: begin
				ctl.op  = OP_EVICT;
				state_d = S_EV_READ;
			end
			S_CP_INIT: begin
				ctl.op  = OP_SCAN_INIT;
				state_d = S_CP_READ;
			end
			S_CP_READ: begin
				if (sts.rem_zero) begin
					ctl.op  = OP_COMPACT_END;
					state_d = S_FD_INIT;
				end else begin
					state_d = S_CP_EVAL;
				end
			end
			S_CP_EVAL: begin
				ctl.op  = OP_COMPACT;
				state_d = S_CP_READ;
			end
			S_FD_INIT: begin
				ctl.op  = OP_SCAN_INIT;
				state_d = S_FD_READ;
			end
			S_FD_READ: begin
				if (sts.rem_zero || sts.stop) begin
					state_d = S_FLUSH;
					unique case (cmd_q)
						CMD_POSITION: ctl.op = OP_PUSH_POS;
						CMD_LOOKUP:   ctl.op = OP_PUSH_LOOK;
						CMD_INSERT: begin
							if (sts.found) begin
								ctl.op = OP_REPLACE;
							end else if (sts.n_full) begin
								ctl.op = OP_PUSH_OVF;
							end else begin
								ctl.op  = OP_SHIFT_INIT;
								state_d = S_SH_READ;
							end
						end
						default: ctl.op = OP_NONE;
					endcase
				end else begin
					state_d = S_FD_EVAL;
				end
			end
			S_FD_EVAL: begin
				ctl.op  = OP_FIND;
				state_d = S_FD_READ;
			end
			S_SH_READ: begin
				if (sts.wr_eq_pos) begin
					ctl.op  = OP_PLACE;
					state_d = S_FLUSH;
				end else begin
					state_d = S_SH_EVAL;
				end
			end
			S_SH_EVAL: begin
				ctl.op  = OP_SHIFT;
				state_d = S_SH_READ;
			end
			S_CN_STOP: begin
				ctl.op  = OP_PUSH_STOP;
				state_d = S_CN_INIT;
			end
			S_CN_INIT: begin
				ctl.op  = OP_SCAN_INIT;
				state_d = S_CN_READ;
			end
			S_CN_READ: begin
				if (sts.rem_zero) begin
					ctl.op  = OP_CLEAR;
					state_d = S_FLUSH;
				end else begin
					state_d = S_CN_EVAL;
				end
			end
			S_CN_EVAL: begin
				ctl.op  = OP_DRAIN;
				state_d = S_CN_READ;
			end
			S_FLUSH: begin
				ctl.op  = OP_FLUSH;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/frame_pool_window_evictor.sv =====
// Top level of the frame pool window evictor: controller plus datapath.
`default_nettype none
// Entries live in a memory kept sorted by frame number, visited one entry at a
// time through its registered read port. A command is taken when start
// is high and busy low; results come out at most one per cycle on result_valid
// with no back-pressure, the final beat of a command flagged by last and
// appearing in the first cycle after busy drops. A lookup scans entries until
// it meets the key or one above it. A position change (ignored while the frame
// length is zero) or an insert first runs eviction: the limit search, a scan of
// the entries, and compaction when anything was evicted; the search follows,
// and an insert also shifts the entries above the new one. Cancel emits a stop
// and then recycles every entry held.
module frame_pool_window_evictor #(
	parameter int SLOTS          = fpwe_pkg::SLOTS_DEF,
	parameter int BUFFER_ID_BITS = fpwe_pkg::BUF_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  fpwe_pkg::in_item_t   item,
	input  wire                  cfg_we,
	input  wire [1:0]            cfg_index,
	input  wire [30:0]           cfg_data,
	output logic                 result_valid,
	output fpwe_pkg::out_item_t  result
);
	import fpwe_pkg::*;

	ctl_t ctl;
	sts_t sts;

	fpwe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (item.cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	fpwe_dp #(
		.SLOTS    (SLOTS),
		.BUF_BITS (BUFFER_ID_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ctl          (ctl),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire
